### sv/lmds_pkg.sv
// shared types, constants and glyph tables of the led matrix scanner
`default_nettype none
package lmds_pkg;

  // block sizing
  localparam int MATRIX_COUNT = 4;
  localparam int BLINK_TICKS  = 500;
  localparam int COLS         = 8;
  localparam int OUT_MATRICES = 4;
  localparam int BLINK_W      = $clog2(BLINK_TICKS);
  localparam int DRAW_COLS    = 6;

  // item queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // action codes of an input item
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_DRAW  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // configuration register indexes
  localparam int         CFG_DATA_W      = 2;
  localparam logic [1:0] CFG_FONT_SELECT = 2'd0;
  localparam logic [1:0] CFG_BRIGHTNESS  = 2'd1;
  localparam logic [1:0] CFG_NETWORK_UP  = 2'd2;

  // brightness levels and on-times
  localparam logic [1:0]  LEVEL_LOW   = 2'd1;
  localparam logic [1:0]  LEVEL_MID   = 2'd2;
  localparam logic [1:0]  LEVEL_HIGH  = 2'd3;
  localparam logic [10:0] ON_TIME_LOW  = 11'd150;
  localparam logic [10:0] ON_TIME_MID  = 11'd500;
  localparam logic [10:0] ON_TIME_HIGH = 11'd1500;

  localparam logic [1:0] FONT_UNUSED = 2'd3;
  localparam logic [3:0] DIGIT_BLANK = 4'd10;
  localparam logic [3:0] FRAME_FULL  = 4'd8;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                          kind;
    logic [4:0]                    base;
    logic [DRAW_COLS-1:0][7:0]     draw_bytes;
    logic [4:0]                    waddr;
    logic [7:0]                    wdata;
  } cmd_t;

  typedef struct packed {
    logic [1:0] font_select;
    logic [1:0] brightness_level;
    logic       network_up;
  } cfg_t;

  localparam logic [7:0] ICON_COLS [COLS] = '{
    8'h04, 8'h0A, 8'h0A, 8'hB2, 8'hB2, 8'h0A, 8'h0A, 8'h04
  };

  localparam logic [4:0] SLOT_BASE [4] = '{5'd10, 5'd2, 5'd23, 5'd16};

  localparam logic [7:0] GLYPH_ROM [3][60] = '{
    '{8'h7C,8'hFE,8'h82,8'h82,8'hFE,8'h7C, 8'h00,8'h84,8'hFE,8'hFE,8'h80,8'h00,
      8'h84,8'hC2,8'hE2,8'hB2,8'h9E,8'h8C, 8'h82,8'h82,8'h92,8'h92,8'hFE,8'h6C,
      8'h3C,8'h3C,8'h20,8'hFE,8'hFE,8'h20, 8'h5E,8'hDE,8'h92,8'h92,8'hF2,8'h62,
      8'h7C,8'hFE,8'h92,8'h92,8'hF2,8'h60, 8'h02,8'hE2,8'hF2,8'h1A,8'h0E,8'h06,
      8'h6C,8'hFE,8'h92,8'h92,8'hFE,8'h6C, 8'h0C,8'h9E,8'h92,8'h92,8'hFE,8'h7C},
    '{8'h7C,8'h82,8'h82,8'h82,8'h82,8'h7C, 8'h00,8'h08,8'h84,8'hFE,8'h80,8'h00,
      8'h84,8'hC2,8'hA2,8'h92,8'h92,8'h8C, 8'h82,8'h82,8'h92,8'h92,8'h92,8'h6C,
      8'h3C,8'h20,8'h20,8'h20,8'hFE,8'h20, 8'h9E,8'h92,8'h92,8'h92,8'h92,8'h62,
      8'h7C,8'h92,8'h92,8'h92,8'h92,8'h60, 8'h02,8'h02,8'hE2,8'h12,8'h0A,8'h06,
      8'h6C,8'h92,8'h92,8'h92,8'h92,8'h6C, 8'h0C,8'h92,8'h92,8'h92,8'h92,8'h7C},
    '{8'h00,8'h7C,8'h82,8'h82,8'h82,8'h7C, 8'h00,8'h00,8'h84,8'hFE,8'h80,8'h00,
      8'h00,8'h84,8'hC2,8'hA2,8'h92,8'h8C, 8'h00,8'h42,8'h82,8'h8A,8'h96,8'h62,
      8'h00,8'h30,8'h28,8'h24,8'hFE,8'h20, 8'h00,8'h4E,8'h8A,8'h8A,8'h8A,8'h72,
      8'h00,8'h78,8'h94,8'h92,8'h92,8'h60, 8'h00,8'h06,8'hC2,8'h22,8'h12,8'h0E,
      8'h00,8'h6C,8'h92,8'h92,8'h92,8'h6C, 8'h00,8'h0C,8'h12,8'h92,8'h92,8'h7C}
  };

  // one glyph column; unused font code falls back to font zero, blank above nine
  function automatic logic [7:0] glyph_byte(logic [1:0] font, logic [3:0] digit,
                                            logic [2:0] col);
    logic [1:0] f;
    logic [5:0] idx;
    f   = (font == FONT_UNUSED) ? 2'd0 : font;
    idx = 6'(digit) * 6'd6 + 6'(col);
    if (digit >= DIGIT_BLANK) begin
      return 8'h00;
    end
    return GLYPH_ROM[f][idx];
  endfunction

endpackage
`default_nettype wire

### sv/lmds_front.sv
// front end: decodes an item and renders the digit columns for a draw
`default_nettype none
module lmds_front import lmds_pkg::*; (
  input  logic [1:0] action_i,
  input  logic [1:0] slot_i,
  input  logic [3:0] old_digit_i,
  input  logic [3:0] new_digit_i,
  input  logic [3:0] slide_frame_i,
  input  logic [4:0] byte_address_i,
  input  logic [7:0] byte_value_i,
  input  logic [1:0] font_select_i,
  output cmd_t       cmd_o
);

  logic [7:0]  ob, nb;
  logic [15:0] mix;

  always_comb begin
    cmd_o.base       = SLOT_BASE[slot_i];
    cmd_o.waddr      = byte_address_i;
    cmd_o.wdata      = byte_value_i;
    cmd_o.draw_bytes = '0;
    ob  = '0;
    nb  = '0;
    mix = '0;
    case (action_i)
      ACT_TICK:  cmd_o.kind = CMD_TICK;
      ACT_DRAW:  cmd_o.kind = CMD_DRAW;
      ACT_WRITE: cmd_o.kind = CMD_WRITE;
      default:   cmd_o.kind = CMD_NOP;
    endcase
    // six independent columns, slide mix shifts old out and new in from the top
    for (int i = 0; i < DRAW_COLS; i++) begin
      ob  = glyph_byte(font_select_i, old_digit_i, 3'(i));
      nb  = glyph_byte(font_select_i, new_digit_i, 3'(i));
      mix = {nb, ob} >> slide_frame_i;
      if (old_digit_i == new_digit_i || slide_frame_i == 4'd0) begin
        cmd_o.draw_bytes[i] = ob;
      end else if (slide_frame_i >= FRAME_FULL) begin
        cmd_o.draw_bytes[i] = nb;
      end else begin
        cmd_o.draw_bytes[i] = mix[7:0];
      end
    end
  end

endmodule
`default_nettype wire

### sv/lmds_queue.sv
// short command queue between front and back
`default_nettype none
module lmds_queue import lmds_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_cmd_o
);

  cmd_t               mem_q [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == Q_CNT_W'(QUEUE_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign pop_cmd_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + Q_CNT_W'(push_i) - Q_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

### sv/lmds_back.sv
// back end: frame buffer, column scan, icon blink and result register
`default_nettype none
module lmds_back import lmds_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  logic                         cmd_valid_i,
  input  cmd_t                         cmd_i,
  output logic                         cmd_pop_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic [7:0]                   col_onehot_o,
  output logic [OUT_MATRICES-1:0][7:0] rows_o,
  output logic [10:0]                  on_time_o,
  output logic                         scan_valid_o
);

  logic [7:0]         fb_q [MATRIX_COUNT][COLS];
  logic [7:0]         fb_d [MATRIX_COUNT][COLS];
  logic [2:0]         col_q, col_d;
  logic [BLINK_W-1:0] blink_q, blink_d;
  logic               icon_q, icon_d;
  logic               blink_wrap;
  logic               is_tick;

  logic                         res_valid_q, res_valid_d;
  logic [7:0]                   res_col_q;
  logic [OUT_MATRICES-1:0][7:0] res_rows_q, rows_now;
  logic [10:0]                  res_on_q, on_now;
  logic                         res_scan_q;

  assign cmd_pop_o  = cmd_valid_i && (!res_valid_q || res_ready_i);
  assign is_tick    = cmd_pop_o && (cmd_i.kind == CMD_TICK);
  assign blink_wrap = is_tick && !cfg_i.network_up &&
                      (blink_q == BLINK_W'(BLINK_TICKS - 1));

  // rows of the current column, absent matrices read zero
  for (genvar m = 0; m < OUT_MATRICES; m++) begin : g_rows
    if (m < MATRIX_COUNT) begin : g_present
      assign rows_now[m] = fb_q[m][col_q];
    end else begin : g_absent
      assign rows_now[m] = 8'h00;
    end
  end

  always_comb begin
    case (cfg_i.brightness_level)
      LEVEL_LOW:  on_now = ON_TIME_LOW;
      LEVEL_MID:  on_now = ON_TIME_MID;
      LEVEL_HIGH: on_now = ON_TIME_HIGH;
      default:    on_now = 11'd0;
    endcase
  end

  always_comb begin
    col_d   = is_tick ? col_q + 3'd1 : col_q;
    blink_d = blink_q;
    icon_d  = icon_q;
    if (is_tick && !cfg_i.network_up) begin
      blink_d = blink_wrap ? '0 : blink_q + 1'b1;
      icon_d  = blink_wrap ? !icon_q : icon_q;
    end
  end

  // buffer update: every entry checks its own address against the command
  always_comb begin
    logic [6:0] addr;
    logic [6:0] off;
    for (int m = 0; m < MATRIX_COUNT; m++) begin
      for (int c = 0; c < COLS; c++) begin
        addr = 7'(m * COLS + c);
        off  = addr - 7'(cmd_i.base);
        fb_d[m][c] = fb_q[m][c];
        if (cmd_pop_o) begin
          case (cmd_i.kind)
            CMD_DRAW: begin
              if (addr >= 7'(cmd_i.base) && off < 7'(DRAW_COLS)) begin
                fb_d[m][c] = cmd_i.draw_bytes[off[2:0]];
              end
            end
            CMD_WRITE: begin
              if (addr == 7'(cmd_i.waddr)) begin
                fb_d[m][c] = cmd_i.wdata;
              end
            end
            CMD_TICK: begin
              if (m == 0 && blink_wrap) begin
                fb_d[m][c] = icon_d ? ICON_COLS[c] : 8'h00;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (cmd_pop_o) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      blink_q     <= '0;
      icon_q      <= 1'b0;
      res_valid_q <= 1'b0;
      for (int m = 0; m < MATRIX_COUNT; m++) begin
        for (int c = 0; c < COLS; c++) begin
          fb_q[m][c] <= 8'h00;
        end
      end
    end else begin
      col_q       <= col_d;
      blink_q     <= blink_d;
      icon_q      <= icon_d;
      res_valid_q <= res_valid_d;
      fb_q        <= fb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      res_scan_q <= is_tick;
      res_col_q  <= is_tick ? (8'd1 << col_q) : 8'h00;
      res_rows_q <= is_tick ? rows_now : '0;
      res_on_q   <= is_tick ? on_now : 11'd0;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign col_onehot_o = res_col_q;
  assign rows_o       = res_rows_q;
  assign on_time_o    = res_on_q;
  assign scan_valid_o = res_scan_q;

endmodule
`default_nettype wire

### sv/led_matrix_digit_display_scanner_unit.sv
// top level of the led matrix column scanner with digit frame buffer
//
// drives four 8x8 led matrices from a 32-byte column frame buffer. every
// accepted item gives exactly one result item, in order. a tick (action 0)
// returns the one-hot column, the four row bytes of that column and the
// on-time of the brightness level, then steps the column; while the network
// is down each tick also counts, and every 500 ticks the no-network icon in
// matrix zero toggles. a draw (action 1) renders a digit slot from the font
// rom with the slide mix, a raw write (action 2) stores one byte; both, and
// action 3, return an all-zero result. rate: one item per clock sustained
// while results are taken; an item's result is registered at the edge where
// it leaves the two-entry command queue. the queue lets input accept items
// while a result waits to be taken, and the frame buffer in the back end is
// updated by one command per cycle whenever a command leaves the queue.
// configuration writes take effect at once and are to be made only while
// the block is idle.
`default_nettype none
module led_matrix_digit_display_scanner_unit import lmds_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration port
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            action_i,
  input  logic [1:0]            slot_i,
  input  logic [3:0]            old_digit_i,
  input  logic [3:0]            new_digit_i,
  input  logic [3:0]            slide_frame_i,
  input  logic [4:0]            byte_address_i,
  input  logic [7:0]            byte_value_i,
  // result items
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            column_onehot_o,
  output logic [7:0]            rows_matrix0_o,
  output logic [7:0]            rows_matrix1_o,
  output logic [7:0]            rows_matrix2_o,
  output logic [7:0]            rows_matrix3_o,
  output logic [10:0]           on_time_us_o,
  output logic                  scan_valid_o
);

  cfg_t cfg_q, cfg_d;
  cmd_t front_cmd, queue_cmd;
  logic q_full, q_valid, q_pop, push;
  logic [OUT_MATRICES-1:0][7:0] rows;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FONT_SELECT: cfg_d.font_select      = cfg_data_i[1:0];
        CFG_BRIGHTNESS:  cfg_d.brightness_level = cfg_data_i[1:0];
        CFG_NETWORK_UP:  cfg_d.network_up       = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.font_select      <= 2'd0;
      cfg_q.brightness_level <= LEVEL_MID;
      cfg_q.network_up       <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input side only waits on queue space
  assign in_ready_o = !q_full;
  assign push       = in_valid_i && !q_full;

  lmds_front u_front (
    .action_i       (action_i),
    .slot_i         (slot_i),
    .old_digit_i    (old_digit_i),
    .new_digit_i    (new_digit_i),
    .slide_frame_i  (slide_frame_i),
    .byte_address_i (byte_address_i),
    .byte_value_i   (byte_value_i),
    .font_select_i  (cfg_q.font_select),
    .cmd_o          (front_cmd)
  );

  lmds_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (front_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (queue_cmd)
  );

  lmds_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_valid_i  (q_valid),
    .cmd_i        (queue_cmd),
    .cmd_pop_o    (q_pop),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .col_onehot_o (column_onehot_o),
    .rows_o       (rows),
    .on_time_o    (on_time_us_o),
    .scan_valid_o (scan_valid_o)
  );

  assign rows_matrix0_o = rows[0];
  assign rows_matrix1_o = rows[1];
  assign rows_matrix2_o = rows[2];
  assign rows_matrix3_o = rows[3];

endmodule
`default_nettype wire

### sv/lmds_checker.sv
// port-level checker of the led matrix scanner and its bind
`default_nettype none
module lmds_checker import lmds_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  column_onehot_o,
  input logic [7:0]  rows_matrix0_o,
  input logic [7:0]  rows_matrix1_o,
  input logic [7:0]  rows_matrix2_o,
  input logic [7:0]  rows_matrix3_o,
  input logic [10:0] on_time_us_o,
  input logic        scan_valid_o
);

  logic       seen_q;
  logic [7:0] last_col_q;
  logic       tick_take;

  assign tick_take = out_valid_o && out_ready_i && scan_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_col_q <= 8'h00;
    end else if (tick_take) begin
      seen_q     <= 1'b1;
      last_col_q <= column_onehot_o;
    end
  end

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(column_onehot_o) &&
      $stable(on_time_us_o) && $stable(scan_valid_o) && $stable(rows_matrix0_o))
    else $error("stalled result changed");

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scan_valid_o |-> $onehot(column_onehot_o))
    else $error("tick column not one-hot");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !scan_valid_o |-> column_onehot_o == 8'h00 &&
      on_time_us_o == 11'd0 && rows_matrix0_o == 8'h00 && rows_matrix1_o == 8'h00 &&
      rows_matrix2_o == 8'h00 && rows_matrix3_o == 8'h00)
    else $error("non-tick result not zero");

  // columns of successive tick results step by one
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scan_valid_o && seen_q |->
      column_onehot_o == {last_col_q[6:0], last_col_q[7]})
    else $error("scan column skipped");

  a_ontime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scan_valid_o |-> on_time_us_o == 11'd0 ||
      on_time_us_o == ON_TIME_LOW || on_time_us_o == ON_TIME_MID ||
      on_time_us_o == ON_TIME_HIGH)
    else $error("bad on-time");

endmodule

bind led_matrix_digit_display_scanner_unit lmds_checker u_lmds_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .column_onehot_o (column_onehot_o),
  .rows_matrix0_o  (rows_matrix0_o),
  .rows_matrix1_o  (rows_matrix1_o),
  .rows_matrix2_o  (rows_matrix2_o),
  .rows_matrix3_o  (rows_matrix3_o),
  .on_time_us_o    (on_time_us_o),
  .scan_valid_o    (scan_valid_o)
);
`default_nettype wire
